@@ rtl/sprd_pkg.sv @@
// Shared types, constants and codes for the slotted page record directory.
// No dependencies.
package sprd_pkg;
   localparam int MaxSlotsDefault     = 32;
   localparam int PageCapacityDefault = 4096;
   localparam int LocLimit            = 4096;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_SEARCH = 2'd1;
   localparam logic [1:0] MODE_DELETE = 2'd2;

   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_NONE     = 2'd1;
   localparam logic [1:0] ST_TOOLARGE = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   // datapath commands
   typedef struct packed {
      logic load;       // capture request, clear walk index
      logic rd;         // read entry at index (and index+1)
      logic step;       // advance walk index
      logic reuse;      // rewrite slot at index as valid with new size
      logic del;        // clear valid at index, widen
      logic shift_init; // set shift pointer to count
      logic shift_mv;   // move entry ptr-1 to ptr, decrement ptr
      logic put;        // write new entry at index+1, count++
      logic put_first;  // write new entry at 0, count++
      logic rsp_load;   // capture result
      logic [1:0] rsp_status;
      logic       rsp_loc_en;
   } sprd_cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       too_large;
      logic       zero_size;
      logic       empty;
      logic       full;
      logic       idx_done;     // index >= count
      logic       cur_valid;
      logic       id_match;
      logic       fit_reuse;
      logic       fit_gap;      // gap after valid entry fits (not full)
      logic       shift_done;   // shift pointer reached index+1
   } sprd_sts_type;
endpackage

@@ rtl/sprd_ctrl.sv @@
// Controller state machine for the slotted page directory.
// Depends on sprd_pkg.
module sprd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  sprd_pkg::sprd_sts_type sts,
   output sprd_pkg::sprd_cmd_type cmd
);
   import sprd_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DEC   = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_EVAL  = 3'd3;
   localparam logic [2:0] S_SHIFT = 3'd4;
   localparam logic [2:0] S_PUT   = 3'd5;
   localparam logic [2:0] S_RSP   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // a waiting result holds off the next transfer so its register stays put
   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !rsp_valid_ff) begin
               cmd.load = 1'b1;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            state_in = S_READ;
            if (sts.mode == MODE_INSERT) begin
               if (sts.too_large) begin
                  cmd.rsp_status = ST_TOOLARGE;
                  state_in = S_RSP;
               end else if (sts.zero_size) begin
                  cmd.rsp_status = ST_NONE;
                  state_in = S_RSP;
               end else if (sts.empty) begin
                  cmd.put_first  = 1'b1;
                  cmd.rsp_status = ST_DONE;
                  state_in = S_RSP;
               end
            end else if (sts.mode != MODE_SEARCH && sts.mode != MODE_DELETE) begin
               cmd.rsp_status = ST_NONE;
               state_in = S_RSP;
            end
            if (state_in == S_READ) begin
               cmd.rd = 1'b1;
            end
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (sts.idx_done) begin
               cmd.rsp_status = (sts.mode == MODE_INSERT && sts.full) ? ST_FULL : ST_NONE;
               state_in = S_RSP;
            end else if (sts.mode == MODE_INSERT) begin
               if (!sts.cur_valid && sts.fit_reuse) begin
                  cmd.reuse = 1'b1;
                  cmd.rsp_status = ST_DONE;
                  state_in = S_RSP;
               end else if (sts.cur_valid && sts.fit_gap) begin
                  cmd.shift_init = 1'b1;
                  state_in = S_SHIFT;
               end else begin
                  cmd.step = 1'b1;
                  cmd.rd   = 1'b1;
                  state_in = S_READ;
               end
            end else if (sts.cur_valid && sts.id_match) begin
               cmd.rsp_status = ST_DONE;
               cmd.rsp_loc_en = 1'b1;
               cmd.del = (sts.mode == MODE_DELETE);
               state_in = S_RSP;
            end else begin
               cmd.step = 1'b1;
               cmd.rd   = 1'b1;
               state_in = S_READ;
            end
            if (state_in == S_RSP) begin
               cmd.rsp_load = 1'b1;
            end
         end
         S_SHIFT: begin
            if (sts.shift_done) begin
               state_in = S_PUT;
            end else begin
               cmd.shift_mv = 1'b1;
            end
         end
         S_PUT: begin
            cmd.put = 1'b1;
            cmd.rsp_status = ST_DONE;
            cmd.rsp_load = 1'b1;
            state_in = S_RSP;
         end
         S_RSP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (state_ff == S_DEC && state_in == S_RSP) begin
         cmd.rsp_load = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

@@ rtl/sprd_dp.sv @@
// Datapath for the slotted page directory: directory memory, walk index,
// fit compares, shift pointer and result register. Depends on sprd_pkg.
module sprd_dp #(
   parameter int MAX_SLOTS     = sprd_pkg::MaxSlotsDefault,
   parameter int PAGE_CAPACITY = sprd_pkg::PageCapacityDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [12:0]            page_size,
   input  logic [1:0]             req_mode,
   input  logic [15:0]            req_record_id,
   input  logic [12:0]            req_record_size,
   input  sprd_pkg::sprd_cmd_type cmd,
   output sprd_pkg::sprd_sts_type sts,
   output logic [1:0]             rsp_status,
   output logic [11:0]            rsp_location
);
   import sprd_pkg::*;

   localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CW = $clog2(MAX_SLOTS + 1);
   localparam int EffCap = (PAGE_CAPACITY < LocLimit) ? PAGE_CAPACITY : LocLimit;
   localparam logic [12:0] EFF_CAP = 13'(EffCap);

   // entry = {id, valid, start, size}
   localparam int EW = 16 + 1 + 12 + 13;
   logic [EW-1:0] mem [MAX_SLOTS];

   logic [1:0]  mode_ff;
   logic [15:0] id_ff;
   logic [12:0] size_ff;
   logic [12:0] eff_ff;
   logic [CW-1:0] cnt_ff;
   logic [CW-1:0] idx_ff;
   logic [CW-1:0] ptr_ff;
   logic [EW-1:0] cur_ff, nxt_ff;
   logic [1:0]  st_ff;
   logic [11:0] loc_ff;
   logic [EW-1:0] mv_ff;
   logic          mv_pend_ff;
   logic [CW-1:0] mv_at_ff;

   logic [15:0] cur_id;
   logic        cur_v;
   logic [11:0] cur_start, nxt_start;
   logic [12:0] cur_size;
   logic [13:0] cur_end;
   logic        has_next;
   logic [CW-1:0] idx_p1;
   logic [12:0] eff_in;

   assign {cur_id, cur_v, cur_start, cur_size} = cur_ff;
   assign nxt_start = nxt_ff[24:13];
   assign cur_end   = {2'b0, cur_start} + {1'b0, cur_size};
   assign idx_p1    = idx_ff + 1'b1;
   assign has_next  = (idx_p1 < cnt_ff);
   assign eff_in    = (page_size > EFF_CAP) ? EFF_CAP : page_size;

   always_comb begin
      sts = '0;
      sts.mode       = mode_ff;
      sts.too_large  = (size_ff > eff_ff);
      sts.zero_size  = (size_ff == 13'd0);
      sts.empty      = (cnt_ff == '0);
      sts.full       = (cnt_ff >= CW'(MAX_SLOTS));
      sts.idx_done   = (idx_ff >= cnt_ff);
      sts.cur_valid  = cur_v;
      sts.id_match   = (cur_id == id_ff);
      sts.fit_reuse  = (size_ff <= cur_size);
      if (has_next) begin
         sts.fit_gap = !sts.full && ({2'b0, nxt_start} >= cur_end) &&
                       ({1'b0, size_ff} <= ({2'b0, nxt_start} - cur_end));
      end else begin
         sts.fit_gap = !sts.full && ({1'b0, eff_ff} >= cur_end) &&
                       ({1'b0, size_ff} <= ({1'b0, eff_ff} - cur_end));
      end
      sts.shift_done = (ptr_ff == idx_p1) && !mv_pend_ff;
   end

   // memory: one read port per address, one write port
   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         cur_ff <= mem[(cmd.step ? idx_p1[IW-1:0] : idx_ff[IW-1:0])];
         nxt_ff <= mem[(cmd.step ? idx_ff[IW-1:0] + IW'(2) : idx_p1[IW-1:0])];
      end
      mv_ff <= mem[IW'(ptr_ff - 1'b1)];
      if (mv_pend_ff) begin
         mem[mv_at_ff[IW-1:0]] <= mv_ff;
      end else if (cmd.put_first) begin
         mem[0] <= {id_ff, 1'b1, 12'd0, size_ff};
      end else if (cmd.put) begin
         mem[idx_p1[IW-1:0]] <= {id_ff, 1'b1, cur_end[11:0], size_ff};
      end else if (cmd.reuse) begin
         mem[idx_ff[IW-1:0]] <= {id_ff, 1'b1, cur_start, size_ff};
      end else if (cmd.del) begin
         if (has_next && ({2'b0, nxt_start} > cur_end)) begin
            mem[idx_ff[IW-1:0]] <= {cur_id, 1'b0, cur_start,
                                    13'({1'b0, nxt_start} - {1'b0, cur_start})};
         end else begin
            mem[idx_ff[IW-1:0]] <= {cur_id, 1'b0, cur_start, cur_size};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         id_ff   <= req_record_id;
         size_ff <= req_record_size;
         eff_ff  <= eff_in;
      end
      if (cmd.rsp_load) begin
         st_ff  <= cmd.rsp_status;
         loc_ff <= cmd.rsp_loc_en ? cur_start : 12'd0;
      end
      mv_at_ff <= ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         idx_ff     <= '0;
         ptr_ff     <= '0;
         mv_pend_ff <= 1'b0;
      end else begin
         if (cmd.load) idx_ff <= '0;
         else if (cmd.step) idx_ff <= idx_p1;
         if (cmd.put || cmd.put_first) cnt_ff <= cnt_ff + 1'b1;
         // shift runs as a read into mv_ff, then the write in the next cycle
         mv_pend_ff <= 1'b0;
         if (cmd.shift_init) begin
            ptr_ff <= cnt_ff;
         end else if (cmd.shift_mv && !mv_pend_ff && ptr_ff != idx_p1) begin
            mv_pend_ff <= 1'b1;
         end else if (mv_pend_ff) begin
            ptr_ff <= ptr_ff - 1'b1;
         end
      end
   end

   assign rsp_status   = st_ff;
   assign rsp_location = loc_ff;
endmodule

@@ rtl/slotted_page_record_directory.sv @@
// One slotted page directory with first-fit insert, search and delete. An item
// rejected at decode gets its result without a walk; otherwise the walk reads one
// directory slot at a time through the memory's registered read, and an insert that
// opens a new entry then moves each later entry up one slot, as a read then a write.
// One item is in work at a time; the input stalls until the result has been taken.
// Depends on sprd_pkg, sprd_ctrl, sprd_dp.
module slotted_page_record_directory #(
   parameter int MAX_SLOTS     = sprd_pkg::MaxSlotsDefault,
   parameter int PAGE_CAPACITY = sprd_pkg::PageCapacityDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [12:0] csr_page_size,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_record_id,
   input  logic [12:0] req_record_size,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [11:0] rsp_location
);
   import sprd_pkg::*;

   logic [12:0]  page_size_ff;
   sprd_cmd_type cmd;
   sprd_sts_type sts;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         page_size_ff <= 13'd4096;
      end else if (csr_valid) begin
         page_size_ff <= csr_page_size;
      end
   end

   sprd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   sprd_dp #(
      .MAX_SLOTS     (MAX_SLOTS),
      .PAGE_CAPACITY (PAGE_CAPACITY)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .page_size       (page_size_ff),
      .req_mode        (req_mode),
      .req_record_id   (req_record_id),
      .req_record_size (req_record_size),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_status      (rsp_status),
      .rsp_location    (rsp_location)
   );
endmodule

@@ rtl/sprd_checker.sv @@
// Port-level checks for the slotted page directory, bound to the top level.
// Depends on sprd_pkg.
module sprd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [11:0] rsp_location
);
   import sprd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_location))
      else $error("stalled result changed");

   a_loc_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_DONE |-> rsp_location == 12'd0)
      else $error("location set on failure");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second transfer taken while busy");

   a_reset_idle: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result after reset");
endmodule

bind slotted_page_record_directory sprd_checker u_sprd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_status   (rsp_status),
   .rsp_location (rsp_location)
);

@@ verif/tb_top.sv @@
// Testbench for slotted_page_record_directory: directed table plus random traffic,
// checked against a behavioral directory predictor. Depends on sprd_pkg and the RTL.
`timescale 1ns / 1ps
module tb_top;
   import sprd_pkg::*;

   localparam int SLOTS = 32;
   localparam int CYCLE_LIMIT = 1500000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [12:0] csr_page_size = 13'd4096;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_mode = MODE_SEARCH;
   logic [15:0] req_record_id = '0;
   logic [12:0] req_record_size = 13'd1;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [11:0] rsp_location;

   slotted_page_record_directory uut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] location;
   } outcome_t;

   typedef struct {
      logic [1:0]  mode;
      logic [15:0] id;
      logic [12:0] size;
      logic        typed;   // expected outcome given in the row
      outcome_t    want;
   } row_t;

   // predictor state
   logic [15:0] dir_id    [SLOTS];
   logic        dir_live  [SLOTS];
   logic [11:0] dir_start [SLOTS];
   logic [12:0] dir_size  [SLOTS];
   int          dir_count;
   int          page_limit;

   outcome_t    pending[$];
   int          fail_count = 0;
   int          rsp_seen = 0;
   int          cycle = 0;
   int          ins_ok = 0;
   int          full_seen = 0;
   bit          hold_long = 1'b0;

   task automatic report(input string what);
      $display("mismatch @%0d: %s", cycle, what);
      fail_count++;
   endtask

   function automatic void open_entry(input int at, input logic [15:0] id,
                                      input int start, input int size);
      for (int k = dir_count; k > at; k--) begin
         dir_id[k]    = dir_id[k-1];
         dir_live[k]  = dir_live[k-1];
         dir_start[k] = dir_start[k-1];
         dir_size[k]  = dir_size[k-1];
      end
      dir_id[at]    = id;
      dir_live[at]  = 1'b1;
      dir_start[at] = start[11:0];
      dir_size[at]  = size[12:0];
      dir_count++;
   endfunction

   function automatic logic [1:0] place_record(input logic [15:0] id, input int rs);
      bit full;
      int stop;
      full = dir_count >= SLOTS;
      if (rs > page_limit) return ST_TOOLARGE;
      if (rs == 0) return ST_NONE;
      if (dir_count == 0) begin
         open_entry(0, id, 0, rs);
         return ST_DONE;
      end
      for (int i = 0; i < dir_count; i++) begin
         stop = int'(dir_start[i]) + int'(dir_size[i]);
         if (dir_live[i]) begin
            if (i + 1 < dir_count) begin
               if (!full && rs <= int'(dir_start[i+1]) - stop) begin
                  open_entry(i + 1, id, stop, rs);
                  return ST_DONE;
               end
            end else if (!full && rs <= page_limit - stop) begin
               open_entry(i + 1, id, stop, rs);
               return ST_DONE;
            end
         end else if (rs <= int'(dir_size[i])) begin
            dir_id[i] = id;
            dir_live[i] = 1'b1;
            dir_size[i] = rs[12:0];
            return ST_DONE;
         end
      end
      return full ? ST_FULL : ST_NONE;
   endfunction

   function automatic outcome_t predict_outcome(input logic [1:0] mode,
                                                input logic [15:0] id,
                                                input logic [12:0] size);
      outcome_t o;
      int hit;
      int stop;
      o.status = ST_NONE;
      o.location = '0;
      if (mode == MODE_INSERT) begin
         o.status = place_record(id, int'(size));
      end else if (mode == MODE_SEARCH || mode == MODE_DELETE) begin
         hit = -1;
         for (int i = 0; i < dir_count; i++)
            if (hit < 0 && dir_live[i] && dir_id[i] == id) hit = i;
         if (hit >= 0) begin
            o.status = ST_DONE;
            o.location = dir_start[hit];
            if (mode == MODE_DELETE) begin
               dir_live[hit] = 1'b0;
               if (hit + 1 < dir_count) begin
                  stop = int'(dir_start[hit]) + int'(dir_size[hit]);
                  if (int'(dir_start[hit+1]) > stop)
                     dir_size[hit] = 13'(int'(dir_start[hit+1]) - int'(dir_start[hit]));
               end
            end
         end
      end
      return o;
   endfunction

   // one transfer on the request channel; expectation logged at acceptance
   task automatic send_item(input logic [1:0] mode, input logic [15:0] id,
                            input logic [12:0] size, input bit typed, input outcome_t want);
      outcome_t o;
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_record_id <= id;
      req_record_size <= size;
      do @(posedge clock); while (req_stall);
      o = predict_outcome(mode, id, size);
      if (mode == MODE_INSERT && o.status == ST_DONE) ins_ok++;
      if (o.status == ST_FULL) full_seen++;
      if (typed && o !== want)
         report($sformatf("table row disagrees with predictor: %h vs %h", want, o));
      pending = {pending, o};
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_page(input logic [12:0] value);
      csr_valid <= 1'b1;
      csr_page_size <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      page_limit = value > 4096 ? 4096 : int'(value);
   endtask

   // result side: random stall per transfer, plus one long hold-off
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         if (pending.size() == 0) begin
            report("result with nothing expected");
         end else begin
            outcome_t w;
            w = pending.pop_front();
            if (rsp_status !== w.status)
               report($sformatf("status %0d want %0d", rsp_status, w.status));
            if (rsp_location !== w.location)
               report($sformatf("location %0d want %0d", rsp_location, w.location));
         end
      end
   end

   initial begin
      int wait_left;
      wait_left = 0;
      forever begin
         @(posedge clock);
         if (hold_long) begin
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            hold_long = 1'b0;
            rsp_stall <= 1'b0;
         end else if (wait_left > 0) begin
            wait_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_valid && !rsp_stall) begin
            wait_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 9);
            rsp_stall <= wait_left > 0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      @(posedge clock);
      while (cycle < CYCLE_LIMIT) @(posedge clock);
      $display("FAIL slotted_page_record_directory");
      $finish;
   end

   row_t table_rows[$];

   function automatic row_t mk(input logic [1:0] m, input logic [15:0] id,
                               input logic [12:0] sz, input bit typed,
                               input logic [1:0] st, input logic [11:0] loc);
      row_t r;
      r.mode = m; r.id = id; r.size = sz; r.typed = typed;
      r.want.status = st; r.want.location = loc;
      return r;
   endfunction

   function automatic void add_row(input row_t r);
      table_rows = {table_rows, r};
   endfunction

   initial begin
      outcome_t none;
      logic [1:0]  m;
      logic [15:0] id;
      logic [12:0] sz;
      int sel;
      none = '0;
      dir_count = 0;
      page_limit = 4096;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table, page 4096 after reset
      add_row(mk(MODE_SEARCH, 16'h0000, 13'd1, 1, ST_NONE, 0));
      add_row(mk(MODE_DELETE, 16'hFFFF, 13'd1, 1, ST_NONE, 0));
      add_row(mk(2'd3, 16'h1234, 13'd5, 1, ST_NONE, 0));
      add_row(mk(MODE_INSERT, 16'h0001, 13'd0, 1, ST_NONE, 0));
      add_row(mk(MODE_INSERT, 16'h0001, 13'd4097, 1, ST_TOOLARGE, 0));
      add_row(mk(MODE_INSERT, 16'h0001, 13'h1FFF, 1, ST_TOOLARGE, 0));
      add_row(mk(MODE_INSERT, 16'hFFFF, 13'd100, 1, ST_DONE, 0));
      add_row(mk(MODE_INSERT, 16'h0000, 13'd200, 1, ST_DONE, 0));
      add_row(mk(MODE_INSERT, 16'hAAAA, 13'd50, 1, ST_DONE, 0));
      add_row(mk(MODE_SEARCH, 16'h0000, 13'd0, 1, ST_DONE, 100));
      add_row(mk(MODE_DELETE, 16'h0000, 13'd0, 1, ST_DONE, 100));
      add_row(mk(MODE_INSERT, 16'h5555, 13'd80, 0, ST_DONE, 0));
      add_row(mk(MODE_INSERT, 16'h5556, 13'd100, 0, ST_DONE, 0));
      add_row(mk(MODE_DELETE, 16'hAAAA, 13'd0, 0, ST_DONE, 0));
      add_row(mk(MODE_INSERT, 16'h7777, 13'd3000, 0, ST_DONE, 0));
      add_row(mk(MODE_INSERT, 16'h7778, 13'd4000, 0, ST_DONE, 0));
      add_row(mk(MODE_SEARCH, 16'h5556, 13'd0, 0, ST_DONE, 0));
      foreach (table_rows[i])
         send_item(table_rows[i].mode, table_rows[i].id, table_rows[i].size,
                   table_rows[i].typed, table_rows[i].want);
      drain();

      // shrink page below last entry end, then the smallest page
      write_page(13'd300);
      send_item(MODE_INSERT, 16'h0042, 13'd1, 0, none);
      send_item(MODE_INSERT, 16'h0043, 13'd301, 1, '{ST_TOOLARGE, 12'd0});
      drain();
      write_page(13'd1);
      send_item(MODE_INSERT, 16'h0044, 13'd2, 1, '{ST_TOOLARGE, 12'd0});
      send_item(MODE_INSERT, 16'h0045, 13'd1, 0, none);
      drain();
      write_page(13'h1FFF);

      // fill the directory with small records to reach the full case
      for (int i = 0; i < 40; i++)
         send_item(MODE_INSERT, 16'(i + 16'h100), 13'($urandom_range(1, 20)), 0, none);

      // pressure: receiver holds off while requests keep coming
      hold_long = 1'b1;
      for (int i = 0; i < 10; i++)
         send_item(MODE_SEARCH, 16'(i + 16'h100), 13'd0, 0, none);
      drain();

      // random phases across page sizes; ids from a small pool mostly
      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: write_page(13'd4096);
            1: write_page(13'd64);
            2: write_page(13'($urandom_range(1, 8191)));
            3: write_page(13'd2048);
            4: write_page(13'd4095);
            5: write_page(13'd1);
            default: write_page(13'd4096);
         endcase
         for (int n = 0; n < 195; n++) begin
            sel = $urandom_range(0, 99);
            m = sel < 45 ? MODE_INSERT : (sel < 70 ? MODE_DELETE :
                (sel < 97 ? MODE_SEARCH : 2'd3));
            id = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 15));
            sel = $urandom_range(0, 19);
            sz = sel == 0 ? 13'($urandom) : (sel < 3 ? 13'($urandom_range(0, 4096)) :
                 13'($urandom_range(1, 300)));
            send_item(m, id, sz, 0, none);
         end
         drain();
      end

      $display("covered %0d results, %0d successful inserts, %0d full-directory results",
               rsp_seen, ins_ok, full_seen);
      if (fail_count == 0)
         $display("PASS slotted_page_record_directory");
      else
         $display("FAIL slotted_page_record_directory");
      $finish;
   end
endmodule
